/* hw/rtl/pwi_pkg.sv */
// Shared types, widths and register codes of the pulse window integrator.
package pwi_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 30;
    localparam int OUT_W       = 46;
    localparam int START_W     = 12;
    localparam int END_W       = 13;
    localparam int TS_W        = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CROSS_GUARD = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_BIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd4;

    localparam logic                   MODE_WINDOW   = 1'b0;
    localparam logic                   MODE_CROSSING = 1'b1;
    localparam logic [START_W-1:0]     START_RESET   = 12'd0;
    localparam logic [END_W-1:0]       END_RESET     = 13'd4096;
    localparam logic signed [SAMPLE_W-1:0] BASE_RESET = 16'sd0;
    localparam logic [TS_W-1:0]        TS_RESET      = 16'hFFFF;

    typedef struct packed {
        logic                       mode;
        logic [START_W-1:0]         start_bin;
        logic [END_W-1:0]           end_bin;
        logic signed [SAMPLE_W-1:0] baseline;
        logic [TS_W-1:0]            time_step;
    } pwi_cfg_t;

    // Finished waveform sum handed from the integrator to the scaler.
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
    } pwi_sum_t;

endpackage

/* hw/rtl/pwi_integrate.sv */
// Input register, per-waveform state and sample selection with accumulation.
module pwi_integrate #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pwi_pkg::pwi_cfg_t                   cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pwi_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last,
    output pwi_pkg::pwi_sum_t                   sum_out,
    input  logic                                sum_ready
);

    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (IDX_W > pwi_pkg::END_W) ? IDX_W : pwi_pkg::END_W;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_SAMPLES);

    logic                                in_valid_reg;
    logic signed [pwi_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                                in_last_reg;

    logic [IDX_W-1:0]                    index_reg,  index_next;
    logic signed [pwi_pkg::ACC_W-1:0]    acc_reg,    acc_next;
    logic signed [pwi_pkg::SAMPLE_W-1:0] prev_reg,   prev_next;
    logic                                stopped_reg, stopped_next;

    logic                                sum_valid_reg;
    logic signed [pwi_pkg::ACC_W-1:0]    sum_reg;

    logic                                advance;
    logic                                in_range;
    logic [CMP_W-1:0]                    idx_c, start_c, end_c, offset;
    logic                                at_or_after_start, before_end, at_start;
    logic signed [pwi_pkg::SAMPLE_W-1:0] prev_sel;
    logic [pwi_pkg::SAMPLE_W:0]          mag_prev, mag_cur;
    logic                                same_sign, opp_sign, do_add;
    logic signed [pwi_pkg::SAMPLE_W:0]   diff;
    logic signed [pwi_pkg::ACC_W-1:0]    acc_added;

    // The sum register hands over to the scaler; a finishing word waits for it.
    assign advance = in_valid_reg && (!in_last_reg || !sum_valid_reg || sum_ready);
    assign s_ready = !in_valid_reg || advance;

    assign sum_out.valid = sum_valid_reg;
    assign sum_out.sum   = sum_reg;

    always_comb begin
        in_range  = index_reg < IDX_LIMIT;
        idx_c     = CMP_W'(index_reg);
        start_c   = CMP_W'(cfg.start_bin);
        end_c     = CMP_W'(cfg.end_bin);
        at_or_after_start = idx_c >= start_c;
        before_end        = idx_c < end_c;
        at_start          = idx_c == start_c;
        offset            = idx_c - start_c;

        prev_sel  = at_start ? in_sample_reg : prev_reg;
        mag_prev  = prev_sel[pwi_pkg::SAMPLE_W-1] ? -{prev_sel[pwi_pkg::SAMPLE_W-1], prev_sel}
                                                  : {1'b0, prev_sel};
        mag_cur   = in_sample_reg[pwi_pkg::SAMPLE_W-1]
                    ? -{in_sample_reg[pwi_pkg::SAMPLE_W-1], in_sample_reg}
                    : {1'b0, in_sample_reg};
        // A zero on either side is neither the same sign nor a sign change.
        same_sign = (prev_sel != '0) && (in_sample_reg != '0)
                    && (prev_sel[pwi_pkg::SAMPLE_W-1] == in_sample_reg[pwi_pkg::SAMPLE_W-1]);
        opp_sign  = (prev_sel != '0) && (in_sample_reg != '0)
                    && (prev_sel[pwi_pkg::SAMPLE_W-1] != in_sample_reg[pwi_pkg::SAMPLE_W-1]);

        diff      = {in_sample_reg[pwi_pkg::SAMPLE_W-1], in_sample_reg}
                    - {cfg.baseline[pwi_pkg::SAMPLE_W-1], cfg.baseline};
        acc_added = acc_reg + pwi_pkg::ACC_W'(diff);

        do_add       = 1'b0;
        stopped_next = stopped_reg;
        if (in_range) begin
            if (cfg.mode == pwi_pkg::MODE_WINDOW) begin
                do_add = at_or_after_start && before_end;
            end else if (at_or_after_start && !stopped_reg) begin
                do_add = same_sign || (mag_prev > mag_cur);
                if ((offset > CMP_W'(pwi_pkg::CROSS_GUARD)) && opp_sign) begin
                    stopped_next = 1'b1;
                end
            end
        end

        acc_next   = do_add ? acc_added : acc_reg;
        index_next = in_range ? index_reg + 1'b1 : index_reg;
        prev_next  = in_range ? in_sample_reg : prev_reg;

        if (in_last_reg) begin
            index_next   = '0;
            acc_next     = '0;
            prev_next    = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            index_reg     <= '0;
            acc_reg       <= '0;
            prev_reg      <= '0;
            stopped_reg   <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                index_reg   <= index_next;
                acc_reg     <= acc_next;
                prev_reg    <= prev_next;
                stopped_reg <= stopped_next;
            end
            if (advance && in_last_reg) begin
                sum_valid_reg <= 1'b1;
            end else if (sum_ready) begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
            in_last_reg   <= s_last;
        end
        if (advance && in_last_reg) begin
            sum_reg <= do_add ? acc_added : acc_reg;
        end
    end

endmodule

/* hw/rtl/pwi_scale.sv */
// Scales a finished waveform sum by the sample period into the output register.
module pwi_scale (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [pwi_pkg::TS_W-1:0]           time_step,
    input  pwi_pkg::pwi_sum_t                  sum_in,
    output logic                               sum_ready,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pwi_pkg::OUT_W-1:0]   m_integral
);

    logic                                  out_valid_reg;
    logic signed [pwi_pkg::OUT_W-1:0]      out_reg;
    logic signed [pwi_pkg::TS_W:0]         ts_signed;
    logic signed [pwi_pkg::ACC_W+pwi_pkg::TS_W:0] product;

    assign sum_ready  = !out_valid_reg || m_ready;
    assign m_valid    = out_valid_reg;
    assign m_integral = out_reg;

    // The period is unsigned; one zero bit on top keeps the product exact.
    assign ts_signed = {1'b0, time_step};
    assign product   = sum_in.sum * ts_signed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            out_valid_reg <= sum_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && sum_in.valid) begin
            out_reg <= product[pwi_pkg::OUT_W-1:0];
        end
    end

endmodule

/* hw/rtl/pulse_window_integrator.sv */
// Top level of the pulse window integrator: configuration registers and datapath.
//
// The block takes one waveform sample per word and sums the samples minus a
// baseline. In window mode (mode 0) it sums samples whose index within the
// waveform lies from start_bin up to, not including, end_bin; the window simply
// ends early if the waveform is shorter. In crossing mode (mode 1) it starts at
// start_bin and adds each sample that has the same sign as the previous one or
// a smaller magnitude; once more than ten samples past start_bin, a sign change
// stops the summing for the rest of the waveform. The word marked last closes
// the waveform: one result word carries the 30-bit wrapped sum times time_step
// (Q15 times unsigned Q0.16, not scaled back), and the per-waveform state
// clears for the next waveform. Words that are not last give no result.
// Samples past MAX_SAMPLES within one waveform are never summed. The block
// takes one word every clock, save for the stall below: the input register
// feeds one stage that selects and accumulates, a second register holds the
// finished sum, and one 30 by 17 bit multiply fills the output register.
// Backpressure on the result channel stalls the input only when a last word
// must hand its sum to a still occupied stage. Configuration writes (cfg_wr_en,
// cfg_index, cfg_wdata) take effect at once and are meant to be made while no
// waveform is in flight; unknown indexes are ignored.
module pulse_window_integrator #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [pwi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pwi_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [pwi_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic                                  s_last,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pwi_pkg::OUT_W-1:0]      m_integral
);

    pwi_pkg::pwi_cfg_t cfg_reg;
    pwi_pkg::pwi_sum_t sum_link;
    logic              sum_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= pwi_pkg::MODE_WINDOW;
            cfg_reg.start_bin <= pwi_pkg::START_RESET;
            cfg_reg.end_bin   <= pwi_pkg::END_RESET;
            cfg_reg.baseline  <= pwi_pkg::BASE_RESET;
            cfg_reg.time_step <= pwi_pkg::TS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pwi_pkg::REG_MODE: begin
                    cfg_reg.mode <= cfg_wdata[0];
                end
                pwi_pkg::REG_START_BIN: begin
                    cfg_reg.start_bin <= cfg_wdata[pwi_pkg::START_W-1:0];
                end
                pwi_pkg::REG_END_BIN: begin
                    cfg_reg.end_bin <= cfg_wdata[pwi_pkg::END_W-1:0];
                end
                pwi_pkg::REG_BASELINE: begin
                    cfg_reg.baseline <= $signed(cfg_wdata[pwi_pkg::SAMPLE_W-1:0]);
                end
                pwi_pkg::REG_TIME_STEP: begin
                    cfg_reg.time_step <= cfg_wdata[pwi_pkg::TS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pwi_integrate #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_integrate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .s_last    (s_last),
        .sum_out   (sum_link),
        .sum_ready (sum_ready)
    );

    pwi_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .time_step  (cfg_reg.time_step),
        .sum_in     (sum_link),
        .sum_ready  (sum_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_integral (m_integral)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the pulse window integrator, with driver, monitor and predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default waveform length limit.
    localparam int MAX_WAVE_LEN = 4096;
    // Generous run limit: roughly two thousand words, the long hold-off, and every
    // configuration pause, taken many times over.
    localparam int CYCLE_LIMIT = 400000;
    // An index that names no register; the block must ignore writes to it.
    localparam logic [pwi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // Cycles allowed after the last result for the pipeline to go quiet.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 500;

    typedef struct packed {
        logic signed [pwi_pkg::SAMPLE_W-1:0] value;
        logic                                last;
    } sample_word_t;

    // Clock and reset.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // Every input of the block starts at a known value.
    logic                                cfg_wr_en = 1'b0;
    logic [pwi_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [pwi_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic signed [pwi_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic                                s_last = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [pwi_pkg::OUT_W-1:0]    m_integral;

    pulse_window_integrator #(
        .MAX_SAMPLES(MAX_WAVE_LEN)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_integral (m_integral)
    );

    // Words waiting to be offered, and integrals predicted but not yet seen.
    sample_word_t                     sample_queue[$];
    logic signed [pwi_pkg::OUT_W-1:0] integral_due[$];

    // Idling controls for the current phase, changed only by nonblocking writes.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        pressure_on = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    // Run statistics.
    int words_accepted = 0;
    int integrals_checked = 0;
    int mismatches = 0;
    int configs_used = 0;
    int cycle_count = 0;

    // Our own copy of the configuration registers, at their reset values.
    logic                                cur_mode = pwi_pkg::MODE_WINDOW;
    logic [pwi_pkg::START_W-1:0]         cur_start = pwi_pkg::START_RESET;
    logic [pwi_pkg::END_W-1:0]           cur_end = pwi_pkg::END_RESET;
    logic signed [pwi_pkg::SAMPLE_W-1:0] cur_baseline = pwi_pkg::BASE_RESET;
    logic [pwi_pkg::TS_W-1:0]            cur_time_step = pwi_pkg::TS_RESET;

    // Our own copy of the per-waveform state.
    int                                  wave_pos = 0;
    logic [pwi_pkg::ACC_W-1:0]           wave_sum = '0;
    logic signed [pwi_pkg::SAMPLE_W-1:0] prior_sample = '0;
    logic                                wave_stopped = 1'b0;

    sample_word_t word_out;

    // Folds one accepted word into the predicted waveform state. A last word
    // closes the waveform: its integral is queued and the state clears.
    function automatic void advance_waveform(logic signed [pwi_pkg::SAMPLE_W-1:0] smp,
                                             logic is_last);
        int                         prev;
        int                         cur;
        longint                     prod;
        int                         mag_prev;
        int                         mag_cur;
        logic                       take;
        longint                     scaled;
        take = 1'b0;
        cur = int'(smp);
        if (wave_pos < MAX_WAVE_LEN) begin
            if (cur_mode == pwi_pkg::MODE_WINDOW) begin
                take = (wave_pos >= int'(cur_start)) && (wave_pos < int'(cur_end));
            end else if (wave_pos >= int'(cur_start) && !wave_stopped) begin
                // At the first crossing sample the sample stands in for its own
                // predecessor, so only a nonzero sample counts as same-signed.
                prev = (wave_pos == int'(cur_start)) ? cur : int'(prior_sample);
                prod = longint'(prev) * longint'(cur);
                mag_prev = (prev < 0) ? -prev : prev;
                mag_cur = (cur < 0) ? -cur : cur;
                // A zero product is neither same sign nor a sign change.
                take = (prod > 0) || (mag_prev > mag_cur);
                // The stop takes hold from the next sample; this one may still count.
                if ((wave_pos - int'(cur_start)) > pwi_pkg::CROSS_GUARD && prod < 0) begin
                    wave_stopped = 1'b1;
                end
            end
            if (take) begin
                wave_sum = wave_sum + pwi_pkg::ACC_W'(cur - int'(cur_baseline));
            end
            prior_sample = smp;
            wave_pos = wave_pos + 1;
        end
        if (is_last) begin
            scaled = longint'($signed(wave_sum)) * longint'(cur_time_step);
            integral_due.push_back(scaled[pwi_pkg::OUT_W-1:0]);
            wave_pos = 0;
            wave_sum = '0;
            prior_sample = '0;
            wave_stopped = 1'b0;
        end
    endfunction

    // Driver: offers queued words, holding each one until it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_waveform(s_sample, s_last);
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_out = sample_queue.pop_front();
                    s_valid <= 1'b1;
                    s_sample <= word_out.value;
                    s_last <= word_out.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: counts its own cycles once pressure is requested,
    // so that the result pipeline fills and the block must stall its input.
    always @(posedge aclk) begin
        if (!pressure_on) begin
            hold_done <= 1'b0;
            hold_left <= 0;
        end else if (!hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks every accepted result against the oldest predicted integral
    // and drives the receiver's ready with random stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (integral_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] unexpected result word: integral %0d, none pending",
                                 $realtime, m_integral);
                    end
                end else begin
                    if (m_integral !== integral_due[0]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] integral mismatch: expected %0d, got %0d",
                                     $realtime, integral_due[0], m_integral);
                        end
                    end
                    void'(integral_due.pop_front());
                    integrals_checked++;
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a run that never drains is a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d integrals still pending.",
                     cycle_count, integral_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Writes one register and mirrors the write into our configuration copy.
    // Only called while no waveform is inside the block.
    task automatic write_reg(input logic [pwi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pwi_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pwi_pkg::REG_MODE:      cur_mode = data[0];
            pwi_pkg::REG_START_BIN: cur_start = data[pwi_pkg::START_W-1:0];
            pwi_pkg::REG_END_BIN:   cur_end = data[pwi_pkg::END_W-1:0];
            pwi_pkg::REG_BASELINE:  cur_baseline = signed'(data);
            pwi_pkg::REG_TIME_STEP: cur_time_step = data;
            default:                ;
        endcase
    endtask

    task automatic push_word(input logic signed [pwi_pkg::SAMPLE_W-1:0] value,
                             input logic is_last);
        sample_word_t w;
        w.value = value;
        w.last = is_last;
        sample_queue.push_back(w);
    endtask

    // Waits until every queued word is taken and every integral has come back,
    // then lets the pipeline settle before any register is touched.
    task automatic drain();
        @(posedge aclk);
        while (sample_queue.size() != 0 || s_valid || integral_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Queues one waveform. Shaped waveforms wander like a real pulse, with runs
    // of one sign, zeros, and sign flips both smaller and larger in magnitude;
    // the rest are raw random words.
    task automatic push_waveform(input int len, input bit shaped);
        int level;
        int r;
        level = $urandom_range(40000) - 20000;
        for (int i = 0; i < len; i++) begin
            if (shaped) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    level = -level / 2;
                end else if (r < 12) begin
                    level = -(level * 3) / 2;
                end else if (r < 16) begin
                    level = 0;
                end else begin
                    level = level + int'($urandom_range(4000)) - 2000;
                end
                if (level > 32767) level = 32767;
                if (level < -32768) level = -32768;
                push_word(pwi_pkg::SAMPLE_W'(level), i == len - 1);
            end else begin
                push_word(pwi_pkg::SAMPLE_W'($urandom()), i == len - 1);
            end
        end
    endtask

    // Draws a new register setting, weighted toward the extremes and toward
    // windows that overlap the short waveforms used in the random part.
    task automatic pick_config();
        int r;
        int start_v;
        int end_v;
        write_reg(pwi_pkg::REG_MODE, pwi_pkg::CFG_DATA_W'($urandom_range(1)));
        r = $urandom_range(99);
        if (r < 8) start_v = 4095;
        else if (r < 25) start_v = 0;
        else start_v = $urandom_range(20);
        write_reg(pwi_pkg::REG_START_BIN, pwi_pkg::CFG_DATA_W'(start_v));
        r = $urandom_range(99);
        if (r < 10) end_v = 4096;
        else if (r < 18) end_v = 0;
        else if (r < 28) end_v = $urandom_range(start_v);
        else end_v = start_v + int'($urandom_range(1, 30));
        if (end_v > 4096) end_v = 4096;
        write_reg(pwi_pkg::REG_END_BIN, pwi_pkg::CFG_DATA_W'(end_v));
        r = $urandom_range(99);
        if (r < 10) write_reg(pwi_pkg::REG_BASELINE, 16'h8000);
        else if (r < 20) write_reg(pwi_pkg::REG_BASELINE, 16'h7FFF);
        else if (r < 50) write_reg(pwi_pkg::REG_BASELINE, pwi_pkg::CFG_DATA_W'($urandom()));
        else write_reg(pwi_pkg::REG_BASELINE,
                       pwi_pkg::CFG_DATA_W'(int'($urandom_range(400)) - 200));
        r = $urandom_range(99);
        if (r < 10) write_reg(pwi_pkg::REG_TIME_STEP, 16'h0000);
        else if (r < 20) write_reg(pwi_pkg::REG_TIME_STEP, 16'hFFFF);
        else write_reg(pwi_pkg::REG_TIME_STEP, pwi_pkg::CFG_DATA_W'($urandom()));
        // Now and then poke an index that holds no register.
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED, pwi_pkg::CFG_DATA_W'($urandom()));
        end
        configs_used++;
    endtask

    initial begin
        int budget;
        int len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part, first at the reset settings: full-scale samples of both
        // signs, a zero, and a waveform that is a single last word.
        configs_used++;
        push_word(16'sh7FFF, 1'b0);
        push_word(16'sh8000, 1'b0);
        push_word(16'sh0000, 1'b0);
        push_word(16'sh0001, 1'b1);
        push_word(16'sh8000, 1'b1);
        drain();

        // The most negative baseline against full-scale positive samples gives the
        // largest per-sample difference.
        write_reg(pwi_pkg::REG_BASELINE, 16'h8000);
        configs_used++;
        push_word(16'sh7FFF, 1'b0);
        push_word(16'sh7FFF, 1'b1);
        drain();

        // Crossing mode from index zero: a zero first sample, a zero predecessor,
        // a smaller opposite-signed sample, a zero after a larger one, and a sign
        // change past the guard that stops the summing.
        write_reg(pwi_pkg::REG_MODE, pwi_pkg::CFG_DATA_W'(pwi_pkg::MODE_CROSSING));
        write_reg(pwi_pkg::REG_BASELINE, 16'h0010);
        write_reg(pwi_pkg::REG_TIME_STEP, 16'h0001);
        configs_used++;
        push_word(16'sd0, 1'b0);
        push_word(16'sd100, 1'b0);
        push_word(16'sd200, 1'b0);
        push_word(-16'sd50, 1'b0);
        push_word(-16'sd60, 1'b0);
        push_word(16'sd0, 1'b0);
        push_word(16'sd7, 1'b0);
        push_word(16'sd9, 1'b0);
        push_word(16'sd10, 1'b0);
        push_word(16'sd11, 1'b0);
        push_word(16'sd12, 1'b0);
        push_word(-16'sd500, 1'b0);
        push_word(16'sd13, 1'b1);
        drain();

        // Window that ends before it starts, so the integral must be zero; an
        // unknown register index is written on the way.
        write_reg(pwi_pkg::REG_MODE, pwi_pkg::CFG_DATA_W'(pwi_pkg::MODE_WINDOW));
        write_reg(pwi_pkg::REG_START_BIN, 16'd5);
        write_reg(pwi_pkg::REG_END_BIN, 16'd3);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(pwi_pkg::REG_TIME_STEP, 16'h1234);
        configs_used++;
        push_waveform(4, 1'b0);
        drain();

        // A window that reaches far past the end of a short waveform, at the
        // largest baseline and period.
        write_reg(pwi_pkg::REG_START_BIN, 16'd2);
        write_reg(pwi_pkg::REG_END_BIN, 16'd4096);
        write_reg(pwi_pkg::REG_BASELINE, 16'h7FFF);
        write_reg(pwi_pkg::REG_TIME_STEP, 16'hFFFF);
        configs_used++;
        push_waveform(6, 1'b1);
        drain();

        // Random part: sixteen phases, each with its own setting, cycling through
        // the idling patterns so that gaps and stalls land on every stage.
        for (int phase = 0; phase < 16; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
                default: begin send_idle_pct <= 11; recv_stall_pct <= 11; end
            endcase
            pick_config();
            budget = 0;
            while (budget < 110) begin
                len = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 40);
                push_waveform(len, $urandom_range(9) < 7);
                budget += len;
            end
            drain();
        end

        // Pressure phase: the receiver holds off for a long stretch while short
        // waveforms keep arriving back to back, so the block must stall its input.
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        write_reg(pwi_pkg::REG_MODE, pwi_pkg::CFG_DATA_W'(pwi_pkg::MODE_WINDOW));
        write_reg(pwi_pkg::REG_START_BIN, 16'd0);
        write_reg(pwi_pkg::REG_END_BIN, 16'd4096);
        write_reg(pwi_pkg::REG_BASELINE, 16'h0000);
        write_reg(pwi_pkg::REG_TIME_STEP, 16'hFFFF);
        configs_used++;
        pressure_on <= 1'b1;
        for (int k = 0; k < 30; k++) begin
            push_waveform($urandom_range(1, 3), 1'b0);
        end
        drain();
        pressure_on <= 1'b0;

        // All stimulus taken and every integral back; allow a last quiet stretch
        // to catch any stray result word.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d integrals from %0d sample words under %0d register settings,",
                 integrals_checked, words_accepted, configs_used);
        $display("in window and crossing modes, with idle, stall and long hold-off phases.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatching result words.", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
